// File: hw/rtl/scs1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_pkg
// Scancode set 1 codes and the US key tables for the set-1 to ASCII decoder.
// ----------------------------------------------------------------------------
package scs1_pkg;

  localparam int unsigned ScanW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned ArrowW = 3;
  localparam int unsigned KeyW   = 6;
  localparam int unsigned OutW   = CharW + 1 + 1 + ArrowW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  localparam logic [ScanW-1:0] LSHIFT_PRESS   = 8'h2A;
  localparam logic [ScanW-1:0] RSHIFT_PRESS   = 8'h36;
  localparam logic [ScanW-1:0] LSHIFT_RELEASE = 8'hAA;
  localparam logic [ScanW-1:0] RSHIFT_RELEASE = 8'hB6;
  localparam logic [ScanW-1:0] CAPS_RELEASE   = 8'hBA;
  localparam logic [ScanW-1:0] CTRL_PRESS     = 8'h1D;
  localparam logic [ScanW-1:0] CTRL_RELEASE   = 8'h9D;
  localparam logic [ScanW-1:0] KEY_UP         = 8'h48;
  localparam logic [ScanW-1:0] KEY_DOWN       = 8'h50;
  localparam logic [ScanW-1:0] KEY_LEFT       = 8'h4B;
  localparam logic [ScanW-1:0] KEY_RIGHT      = 8'h4D;
  localparam logic [ScanW-1:0] KEY_L          = 8'h26;
  localparam logic [ScanW-1:0] TABLE_LEN      = 8'd58;

  typedef enum logic [ArrowW-1:0] {
    ARROW_NONE  = 3'd0,
    ARROW_UP    = 3'd1,
    ARROW_DOWN  = 3'd2,
    ARROW_LEFT  = 3'd3,
    ARROW_RIGHT = 3'd4
  } arrow_t;

  typedef struct packed {
    logic [ArrowW-1:0] arrow_code;
    logic              clear_screen;
    logic              char_valid;
    logic [CharW-1:0]  ascii_char;
  } result_t;

  // Digit and punctuation keys: case comes from shift alone.
  function automatic logic shift_only(input logic [KeyW-1:0] k);
    return (k <= 6'd13) || (k == 6'd26) || (k == 6'd27) || (k == 6'd43) ||
           (k >= 6'd39 && k <= 6'd41) || (k >= 6'd51 && k <= 6'd53);
  endfunction

  function automatic logic [CharW-1:0] plain_char(input logic [KeyW-1:0] k);
    logic [CharW-1:0] c;
    unique case (k)
      6'd1:  c = 7'h1B;  6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;  6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;  6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;
      6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;
      6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6F;
      6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;  6'd28: c = 7'h0A;
      6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
      6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
      6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
      6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted symbols of the shift-only keys.
  function automatic logic [CharW-1:0] shift_symbol(input logic [KeyW-1:0] k);
    logic [CharW-1:0] c;
    unique case (k)
      6'd1:  c = 7'h1B;  6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;  6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;  6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;
      6'd13: c = 7'h2B;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;  6'd39: c = 7'h3A;
      6'd40: c = 7'h22;  6'd41: c = 7'h7E;  6'd43: c = 7'h7C;  6'd51: c = 7'h3C;
      6'd52: c = 7'h3E;  6'd53: c = 7'h3F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/scancode_set1_to_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat goes through the input register and then the result register.
// Throughput: 1 beat per cycle; the input register and the result register form a
// two-stage pipeline that advances whenever the result register is empty or taken.
// Reset (rst, synchronous, active high) clears shift, caps lock, ctrl and both
// valid flags.
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Keeps shift, caps lock and ctrl flags and translates set-1 press codes to
// ASCII, with Ctrl+L reported as clear screen and arrow presses as a code.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [6:0] ascii_char, [7] char_valid,
                                      // [8] clear_screen, [11:9] arrow_code, zero pad
);

  logic shift_held, caps_on, ctrl_held;
  logic shift_next, caps_next, ctrl_next;

  // input register: byte and the flags as updated by that byte
  logic                          in_valid;
  logic [scs1_pkg::ScanW-1:0]    in_byte;
  logic                          in_shift, in_caps, in_ctrl;

  scs1_pkg::result_t             res, res_next;
  logic                          out_valid;

  logic s_accept, in_advance;

  assign in_advance = in_valid && (!out_valid || m_tready);
  assign s_tready   = !in_valid || in_advance;
  assign s_accept   = s_tvalid && s_tready;

  always_comb begin
    shift_next = shift_held;
    caps_next  = caps_on;
    ctrl_next  = ctrl_held;
    if (s_tdata == scs1_pkg::LSHIFT_PRESS || s_tdata == scs1_pkg::RSHIFT_PRESS) begin
      shift_next = 1'b1;
    end else if (s_tdata == scs1_pkg::LSHIFT_RELEASE ||
                 s_tdata == scs1_pkg::RSHIFT_RELEASE) begin
      shift_next = 1'b0;
    end
    if (s_tdata == scs1_pkg::CAPS_RELEASE) begin
      caps_next = !caps_on;
    end
    if (s_tdata == scs1_pkg::CTRL_PRESS) begin
      ctrl_next = 1'b1;
    end else if (s_tdata == scs1_pkg::CTRL_RELEASE) begin
      ctrl_next = 1'b0;
    end
  end

  // translation of the registered byte
  logic [scs1_pkg::KeyW-1:0]  key;
  logic                       only_shift, up, is_press, in_table;
  logic [scs1_pkg::CharW-1:0] plain, ch;

  always_comb begin
    key        = in_byte[scs1_pkg::KeyW-1:0];
    is_press   = !in_byte[scs1_pkg::ScanW-1];
    in_table   = in_byte < scs1_pkg::TABLE_LEN;
    only_shift = scs1_pkg::shift_only(key);
    up         = only_shift ? in_shift : (in_shift ^ in_caps);
    plain      = scs1_pkg::plain_char(key);
    if (!up) begin
      ch = plain;
    end else if (only_shift) begin
      ch = scs1_pkg::shift_symbol(key);
    end else if (plain[6:5] == 2'b11) begin
      ch = plain & 7'h5F;  // letter: fold to upper case
    end else begin
      ch = plain;
    end

    res_next = '0;
    unique case (in_byte)
      scs1_pkg::KEY_UP:    res_next.arrow_code = scs1_pkg::ARROW_UP;
      scs1_pkg::KEY_DOWN:  res_next.arrow_code = scs1_pkg::ARROW_DOWN;
      scs1_pkg::KEY_LEFT:  res_next.arrow_code = scs1_pkg::ARROW_LEFT;
      scs1_pkg::KEY_RIGHT: res_next.arrow_code = scs1_pkg::ARROW_RIGHT;
      default:             res_next.arrow_code = scs1_pkg::ARROW_NONE;
    endcase
    if (is_press && in_table) begin
      if (in_ctrl && in_byte == scs1_pkg::KEY_L) begin
        res_next.clear_screen = 1'b1;
      end else if (ch != '0) begin
        res_next.ascii_char = ch;
        res_next.char_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
      ctrl_held  <= 1'b0;
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s_accept) begin
        shift_held <= shift_next;
        caps_on    <= caps_next;
        ctrl_held  <= ctrl_next;
        in_valid   <= 1'b1;
      end else if (in_advance) begin
        in_valid   <= 1'b0;
      end
      if (in_advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte  <= s_tdata;
      in_shift <= shift_next;
      in_caps  <= caps_next;
      in_ctrl  <= ctrl_next;
    end
    if (in_advance) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(scs1_pkg::OutBytesW - scs1_pkg::OutW)'(0), res};

  // ---------------------------------------------------------------------------
  ca_caps_toggle: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tdata == scs1_pkg::CAPS_RELEASE |=> caps_on != $past(caps_on))
    else $error("caps lock did not toggle on caps release");

  ca_clear_no_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.clear_screen && res.char_valid))
    else $error("clear screen reported together with a character");

  ca_arrow_no_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.arrow_code != scs1_pkg::ARROW_NONE |-> !res.char_valid)
    else $error("arrow key produced a character");

  ca_valid_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.char_valid == (res.ascii_char != '0)))
    else $error("char_valid disagrees with ascii_char");

  ca_no_lost_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(res))
    else $error("stalled result changed");

endmodule
`default_nettype wire
